### hdl/indexed_list_insert_remove_macros.svh
// Assertion macros shared by the indexed list design.
`ifndef INDEXED_LIST_INSERT_REMOVE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ILIR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("indexed list assertion failed");

// Next-cycle implication, checked outside reset.
`define ILIR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("indexed list assertion failed");

`endif

### hdl/ilir_pkg.sv
// Package: sizes, operation and status codes, and the broadcast to the cell row.
package ilir_pkg;

   localparam int DEPTH      = 16;
   localparam int KIND_W     = 3;
   localparam int INDEX_W    = 5;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_F_W  = 5;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 3'd0,
      KIND_DROP   = 3'd1,
      KIND_INSERT = 3'd2,
      KIND_REMOVE = 3'd3,
      KIND_READ   = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [CMP_W-1:0]   index;
      logic [CMP_W-1:0]   count;
      logic [VALUE_W-1:0] value;
   } bcast_type;

endpackage

### hdl/ilir_cell.sv
// One list position: holds an entry and moves it to or from its neighbors.
module ilir_cell import ilir_pkg::*; (
   input  logic               clock,
   input  logic [CMP_W-1:0]   cell_pos,
   input  bcast_type          bcast,
   input  logic [VALUE_W-1:0] left_entry,
   input  logic [VALUE_W-1:0] right_entry,
   output logic [VALUE_W-1:0] entry,
   output logic [VALUE_W-1:0] hit_entry
);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               at_index;

   assign at_index = (cell_pos == bcast.index);

   always_comb begin
      entry_in = entry_ff;
      case (bcast.op)
         CELL_APPEND: begin
            if (cell_pos == bcast.count) entry_in = bcast.value;
         end
         CELL_INSERT: begin
            if (at_index) begin
               entry_in = bcast.value;
            end else if ((cell_pos > bcast.index) && (cell_pos <= bcast.count)) begin
               entry_in = left_entry;
            end
         end
         CELL_REMOVE: begin
            if ((cell_pos >= bcast.index) && ((cell_pos + CMP_W'(1)) < bcast.count)) begin
               entry_in = right_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry     = entry_ff;
   assign hit_entry = at_index ? entry_ff : '0;

endmodule

### hdl/ilir_ctrl.sv
// Control: decodes the operation, keeps the count, registers the result.
module ilir_ctrl import ilir_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [KIND_W-1:0]    kind,
   input  logic [INDEX_W-1:0]   index,
   input  logic [VALUE_W-1:0]   value,
   input  logic [VALUE_W-1:0]   read_entry,
   output bcast_type            bcast,
   output logic                 rsp_valid,
   output logic [VALUE_W-1:0]   rsp_read_value,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_F_W-1:0] rsp_count
);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] read_value_ff;
   logic [VALUE_W-1:0] read_value_in;
   status_type         status_ff;
   status_type         status_in;
   cell_op_type        op;
   logic [CMP_W-1:0]   idx_x;
   logic [CMP_W-1:0]   cnt_x;
   logic               full;

   assign idx_x = CMP_W'(index);
   assign cnt_x = CMP_W'(count_ff);
   assign full  = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      op            = CELL_HOLD;
      count_in      = count_ff;
      status_in     = ST_DONE;
      read_value_in = '0;
      unique case (kind_type'(kind))
         KIND_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               op       = CELL_APPEND;
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_DROP: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         KIND_INSERT: begin
            if (idx_x > cnt_x) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               op       = CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_REMOVE: begin
            if (idx_x >= cnt_x) begin
               status_in = ST_RANGE;
            end else begin
               op       = CELL_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         KIND_READ: begin
            if (idx_x >= cnt_x) begin
               status_in     = ST_RANGE;
               read_value_in = '1;
            end else begin
               read_value_in = read_entry;
            end
         end
         default: begin
            op = CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         status_ff     <= status_in;
      end
   end

   assign bcast.op    = accept ? op : CELL_HOLD;
   assign bcast.index = idx_x;
   assign bcast.count = cnt_x;
   assign bcast.value = value;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = COUNT_F_W'(count_ff);

endmodule

### hdl/indexed_list_insert_remove.sv
// Top level: ordered list of signed entries held in a row of shifting cells.
//
//   channel   direction  handshake               payload
//   request   in         start && !busy          req_kind, req_index, req_value
//   result    out        rsp_valid (one cycle)   rsp_read_value, rsp_status, rsp_count
//
// One transfer per cycle: busy stays low, since the affected cells all shift to
// their neighbor at the same clock edge.
// The result strobes in the cycle after the request transfer.
// Synchronous reset empties the list; entry contents are not cleared.
// The receiver cannot stall; results are never held back.
`include "indexed_list_insert_remove_macros.svh"

module indexed_list_insert_remove import ilir_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [INDEX_W-1:0]   req_index,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                 rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_F_W-1:0] rsp_count
);

   logic               accept;
   bcast_type          bcast;
   logic [VALUE_W-1:0] entries   [DEPTH];
   logic [VALUE_W-1:0] hits      [DEPTH];
   logic [VALUE_W-1:0] lefts     [DEPTH];
   logic [VALUE_W-1:0] rights    [DEPTH];
   logic [VALUE_W-1:0] read_entry;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ilir_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .kind           (req_kind),
      .index          (req_index),
      .value          (req_value),
      .read_entry     (read_entry),
      .bcast          (bcast),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lefts[i] = entries[i];
      end else begin : g_mid_l
         assign lefts[i] = entries[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rights[i] = entries[i];
      end else begin : g_mid_r
         assign rights[i] = entries[i+1];
      end

      ilir_cell u_cell (
         .clock       (clock),
         .cell_pos    (CMP_W'(i)),
         .bcast       (bcast),
         .left_entry  (lefts[i]),
         .right_entry (rights[i]),
         .entry       (entries[i]),
         .hit_entry   (hits[i])
      );
   end

   // at most one cell matches the index; OR the gated outputs
   always_comb begin
      read_entry = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_entry = read_entry | hits[i];
      end
   end

   `ILIR_ASSERT_NEXT(a_rsp_after_transfer, accept, rsp_valid)
   `ILIR_ASSERT_NEXT(a_no_rsp_without_transfer, !accept, !rsp_valid)
   `ILIR_ASSERT_NOW(a_count_in_range, 1'b1, bcast.count <= CMP_W'(DEPTH))
   `ILIR_ASSERT_NOW(a_full_status_count, rsp_valid && (rsp_status == ST_FULL),
                    bcast.count == CMP_W'(DEPTH))

endmodule

### tb/tb_indexed_list_insert_remove.sv
// Testbench for indexed_list_insert_remove: directed table plus predictor-checked random traffic.
module tb_indexed_list_insert_remove;
   import ilir_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
   localparam int RANDOM_ITEMS   = 410;
   localparam int CALM_TAIL      = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int DRAIN_CYCLES   = 4;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      status_type                status;
      logic [COUNT_F_W-1:0]      count;
   } list_rsp_type;

   typedef struct packed {
      bit           typed;
      list_rsp_type answer;
   } answer_tag_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
      bit                        typed;
      list_rsp_type              answer;
   } list_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [KIND_W-1:0]           req_kind = '0;
   logic [INDEX_W-1:0]          req_index = '0;
   logic signed [VALUE_W-1:0]   req_value = '0;
   logic                        rsp_valid;
   logic signed [VALUE_W-1:0]   rsp_read_value;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_F_W-1:0]        rsp_count;

   logic signed [VALUE_W-1:0]   list_cells [DEPTH];
   int                          list_len = 0;
   list_rsp_type                due_results [$];
   answer_tag_type              typed_answers [$];
   int                          mismatches = 0;
   int                          quiet_cycles = 0;

   indexed_list_insert_remove u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic apply_list_op(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                                input logic signed [VALUE_W-1:0] val, output list_rsp_type res);
      int pos;
      res.read_value = '0;
      res.status     = ST_DONE;
      pos            = int'(idx);
      case (kind)
         KIND_APPEND: begin
            if (list_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               list_cells[list_len] = val;
               list_len++;
            end
         end
         KIND_DROP: begin
            if (list_len == 0) res.status = ST_EMPTY;
            else list_len--;
         end
         KIND_INSERT: begin
            if (pos > list_len) begin
               res.status = ST_RANGE;
            end else if (list_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
               list_cells[pos] = val;
               list_len++;
            end
         end
         KIND_REMOVE: begin
            if (pos >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
               list_len--;
            end
         end
         KIND_READ: begin
            if (pos >= list_len) begin
               res.read_value = -1;
               res.status     = ST_RANGE;
            end else begin
               res.read_value = list_cells[pos];
            end
         end
         default: ;
      endcase
      res.count = COUNT_F_W'(list_len);
   endtask

   // check results, then book the transfer taken at this edge
   always @(posedge clock) begin : list_monitor
      list_rsp_type   got;
      list_rsp_type   want;
      list_rsp_type   model;
      answer_tag_type tag;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_valid) begin
            quiet_cycles = 0;
            got.read_value = rsp_read_value;
            got.status     = status_type'(rsp_status);
            got.count      = rsp_count;
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result: read_value %0d status %0d count %0d",
                           got.read_value, got.status, got.count);
            end else begin
               want = due_results.pop_front();
               if (got.read_value !== want.read_value || got.status !== want.status ||
                   got.count !== want.count) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("mismatch: read_value %0d/%0d status %0d/%0d count %0d/%0d",
                              want.read_value, got.read_value, want.status, got.status,
                              want.count, got.count);
               end
            end
         end
         if (start && !busy) begin
            quiet_cycles = 0;
            apply_list_op(req_kind, req_index, req_value, model);
            tag = typed_answers.pop_front();
            due_results.insert(due_results.size(), tag.typed ? tag.answer : model);
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic list_row_type mk_row(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                           logic signed [VALUE_W-1:0] val, bit typed,
                                           logic signed [VALUE_W-1:0] rd, status_type st,
                                           int cnt);
      list_row_type r;
      r.kind              = kind;
      r.index             = idx;
      r.value             = val;
      r.typed             = typed;
      r.answer.read_value = rd;
      r.answer.status     = st;
      r.answer.count      = COUNT_F_W'(cnt);
      return r;
   endfunction

   task automatic transfer_op(input list_row_type r);
      typed_answers.insert(typed_answers.size(), answer_tag_type'{r.typed, r.answer});
      req_kind  <= r.kind;
      req_index <= r.index;
      req_value <= r.value;
      start     <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic maybe_idle(input int percent);
      if ($urandom_range(0, 99) < percent) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return -1;
         3:       return 0;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      list_row_type rows [$];
      list_row_type r;
      int        fill_at;
      int        mode;
      int        idle_pct;
      int        left;
      int        pick;
      logic [KIND_W-1:0] k;

      rows.insert(rows.size(), mk_row(KIND_DROP,   0, 0, 1, 0, ST_EMPTY, 0));
      rows.insert(rows.size(), mk_row(KIND_READ,   0, 0, 1, -1, ST_RANGE, 0));
      rows.insert(rows.size(), mk_row(KIND_REMOVE, 0, 0, 1, 0, ST_RANGE, 0));
      rows.insert(rows.size(), mk_row(KIND_INSERT, 1, 5, 1, 0, ST_RANGE, 0));
      rows.insert(rows.size(), mk_row(KIND_INSERT, 0, 32'sh8000_0000, 1, 0, ST_DONE, 1));
      rows.insert(rows.size(), mk_row(KIND_APPEND, 0, 32'sh7FFF_FFFF, 1, 0, ST_DONE, 2));
      rows.insert(rows.size(), mk_row(KIND_READ,   0, 0, 1, 32'sh8000_0000, ST_DONE, 2));
      rows.insert(rows.size(), mk_row(KIND_READ,   1, 0, 1, 32'sh7FFF_FFFF, ST_DONE, 2));
      rows.insert(rows.size(), mk_row(KIND_INSERT, 1, -1, 0, 0, ST_DONE, 0));
      rows.insert(rows.size(), mk_row(KIND_INSERT, 3, 32'sh5A5A_A5A5, 0, 0, ST_DONE, 0));
      rows.insert(rows.size(), mk_row(KIND_READ,   31, 0, 1, -1, ST_RANGE, 4));
      rows.insert(rows.size(), mk_row(KIND_REMOVE, 1, 0, 0, 0, ST_DONE, 0));
      rows.insert(rows.size(), mk_row(KIND_REMOVE, 3, 0, 1, 0, ST_RANGE, 3));
      rows.insert(rows.size(), mk_row(KIND_SPARE_FIRST, 0, 7, 1, 0, ST_DONE, 3));
      rows.insert(rows.size(), mk_row(KIND_SPARE_LAST, 31, -1, 1, 0, ST_DONE, 3));
      rows.insert(rows.size(), mk_row(KIND_READ,   2, 0, 0, 0, ST_DONE, 0));
      rows.insert(rows.size(), mk_row(KIND_DROP,   0, 0, 1, 0, ST_DONE, 2));
      fill_at = rows.size();
      rows.insert(rows.size(), mk_row(KIND_APPEND, 0, 1, 1, 0, ST_FULL, DEPTH));
      rows.insert(rows.size(), mk_row(KIND_INSERT, INDEX_W'(DEPTH), 1, 1, 0, ST_FULL, DEPTH));
      rows.insert(rows.size(),
                  mk_row(KIND_INSERT, INDEX_W'(DEPTH + 1), 1, 1, 0, ST_RANGE, DEPTH));
      rows.insert(rows.size(), mk_row(KIND_INSERT, 0, 1, 1, 0, ST_FULL, DEPTH));
      rows.insert(rows.size(), mk_row(KIND_READ,   INDEX_W'(DEPTH - 1), 0, 0, 0, ST_DONE, 0));
      rows.insert(rows.size(), mk_row(KIND_READ,   INDEX_W'(DEPTH), 0, 1, -1, ST_RANGE, DEPTH));
      rows.insert(rows.size(),
                  mk_row(KIND_REMOVE, INDEX_W'(DEPTH - 1), 0, 1, 0, ST_DONE, DEPTH - 1));
      rows.insert(rows.size(), mk_row(KIND_REMOVE, 0, 0, 1, 0, ST_DONE, DEPTH - 2));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         // fill to capacity; surplus appends hit the full case
         if (i == fill_at)
            repeat (DEPTH) begin
               transfer_op(mk_row(KIND_APPEND, 0, pick_value(), 0, 0, ST_DONE, 0));
               maybe_idle(20);
            end
         transfer_op(rows[i]);
         maybe_idle(25);
      end

      left     = 0;
      mode     = 0;
      idle_pct = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (left == 0) begin
            left     = $urandom_range(10, 40);
            mode     = $urandom_range(0, 2);
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
         end
         left--;
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            k = KIND_SPARE_FIRST + KIND_W'($urandom_range(0, 2));
         end else begin
            case (mode)
               0: k = (pick < 45) ? KIND_APPEND : (pick < 75) ? KIND_INSERT :
                      (pick < 90) ? KIND_READ : (pick < 95) ? KIND_REMOVE : KIND_DROP;
               1: k = (pick < 33) ? KIND_DROP : (pick < 68) ? KIND_REMOVE :
                      (pick < 83) ? KIND_READ : (pick < 92) ? KIND_APPEND : KIND_INSERT;
               default: k = (pick < 22) ? KIND_APPEND : (pick < 42) ? KIND_INSERT :
                            (pick < 62) ? KIND_READ : (pick < 82) ? KIND_REMOVE : KIND_DROP;
            endcase
         end
         r = mk_row(k, ($urandom_range(0, 4) == 0) ? INDEX_W'($urandom_range(0, 31)) :
                       INDEX_W'($urandom_range(0, DEPTH)),
                    pick_value(), 0, 0, ST_DONE, 0);
         transfer_op(r);
         if (n < RANDOM_ITEMS - CALM_TAIL) maybe_idle(idle_pct);
      end

      start <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_results.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
